// ===== rtl/uart8n1_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the 8N1 UART transceiver.
package uart8n1_pkg;

  localparam int unsigned DataBits = 8;
  localparam int unsigned TimerW   = 24;
  localparam int unsigned UsecW    = 10;
  localparam int unsigned TmoW     = 32;
  localparam int unsigned TxIdxW   = $clog2(DataBits + 3);
  localparam int unsigned RxIdxW   = $clog2(DataBits + 1);

  localparam logic [TimerW-1:0] CyclesPerBitRst = TimerW'(6076);
  localparam logic [UsecW-1:0]  TicksPerUsecRst = UsecW'(700);

  typedef enum logic [0:0] {
    CfgCyclesPerBit = 1'b0,
    CfgTicksPerUsec = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic level;
    logic busy;
  } tx_stat_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DataBits-1:0] data;
    logic                timeout;
  } rx_stat_t;

endpackage

// ===== rtl/uart8n1_tx.sv =====
`timescale 1ns / 1ps
// Transmit framer: start bit, data LSB first, stop bit, one tick per word.
module uart8n1_tx (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [uart8n1_pkg::TimerW-1:0]      period_i,
  input  logic                                send_start_i,
  input  logic [uart8n1_pkg::DataBits-1:0]    send_byte_i,
  output uart8n1_pkg::tx_stat_t               stat_o
);

  logic                                active_q, active_d;
  logic [uart8n1_pkg::DataBits-1:0]    shift_q, shift_d;
  logic [uart8n1_pkg::TxIdxW-1:0]      idx_q, idx_d;
  logic [uart8n1_pkg::TimerW-1:0]      timer_q, timer_d;
  logic                                line_q, line_d;
  logic [uart8n1_pkg::TimerW-1:0]      timer_inc;
  logic [uart8n1_pkg::TxIdxW-1:0]      idx_inc;

  assign timer_inc = timer_q + uart8n1_pkg::TimerW'(1);
  assign idx_inc   = idx_q + uart8n1_pkg::TxIdxW'(1);

  always_comb begin
    active_d = active_q;
    shift_d  = shift_q;
    idx_d    = idx_q;
    timer_d  = timer_q;
    line_d   = line_q;
    if (active_q) begin
      timer_d = timer_inc;
      if (timer_inc >= period_i) begin
        timer_d = '0;
        idx_d   = idx_inc;
        if (idx_inc > uart8n1_pkg::TxIdxW'(uart8n1_pkg::DataBits + 1)) begin
          active_d = 1'b0;
          idx_d    = '0;
          line_d   = 1'b1;
        end else if (idx_inc <= uart8n1_pkg::TxIdxW'(uart8n1_pkg::DataBits)) begin
          // data slot idx_inc carries bit idx_q
          line_d = shift_q[idx_q[$clog2(uart8n1_pkg::DataBits)-1:0]];
        end else begin
          line_d = 1'b1;
        end
      end
    end else if (send_start_i) begin
      active_d = 1'b1;
      shift_d  = send_byte_i;
      idx_d    = '0;
      timer_d  = '0;
      line_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      shift_q  <= '0;
      idx_q    <= '0;
      timer_q  <= '0;
      line_q   <= 1'b1;
    end else if (step_i) begin
      active_q <= active_d;
      shift_q  <= shift_d;
      idx_q    <= idx_d;
      timer_q  <= timer_d;
      line_q   <= line_d;
    end
  end

  assign stat_o.level = line_d;
  assign stat_o.busy  = active_d;

endmodule

// ===== rtl/uart8n1_rx.sv =====
`timescale 1ns / 1ps
// Receive sequencer: start-bit wait with timeout, mid-bit sampling, stop wait.
module uart8n1_rx (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [uart8n1_pkg::TimerW-1:0]      period_i,
  input  logic [uart8n1_pkg::UsecW-1:0]       ticks_per_usec_i,
  input  logic                                rx_level_i,
  input  logic                                recv_start_i,
  input  logic [uart8n1_pkg::TmoW-1:0]        wait_usec_i,
  output uart8n1_pkg::rx_stat_t               stat_o
);

  typedef enum logic [2:0] {
    PhIdle = 3'd0,
    PhWait = 3'd1,
    PhHalf = 3'd2,
    PhData = 3'd3,
    PhStop = 3'd4
  } rx_phase_e;

  rx_phase_e                           phase_q, phase_d, phase_w;
  logic [uart8n1_pkg::TimerW-1:0]      timer_q, timer_d, timer_w, timer_inc;
  logic [uart8n1_pkg::UsecW-1:0]       pre_q, pre_d, pre_w, pre_inc;
  logic [uart8n1_pkg::TmoW-1:0]        left_q, left_d, left_w;
  logic [uart8n1_pkg::DataBits-1:0]    shift_q, shift_d, shift_w;
  logic [uart8n1_pkg::RxIdxW-1:0]      idx_q, idx_d, idx_w, idx_inc;
  logic                                armed;
  logic                                done, tmo;
  logic [uart8n1_pkg::TimerW-1:0]      half;

  assign half = period_i >> 1;

  always_comb begin
    // load on arming, then run this tick's phase step
    armed   = 1'b0;
    phase_w = phase_q;
    timer_w = timer_q;
    pre_w   = pre_q;
    left_w  = left_q;
    shift_w = shift_q;
    idx_w   = idx_q;
    if (phase_q == PhIdle && recv_start_i) begin
      armed   = 1'b1;
      phase_w = PhWait;
      left_w  = wait_usec_i;
      pre_w   = '0;
      shift_w = '0;
      idx_w   = '0;
      timer_w = '0;
    end

    timer_inc = timer_w + uart8n1_pkg::TimerW'(1);
    pre_inc   = pre_w + uart8n1_pkg::UsecW'(1);
    idx_inc   = idx_w + uart8n1_pkg::RxIdxW'(1);

    phase_d = phase_w;
    timer_d = timer_w;
    pre_d   = pre_w;
    left_d  = left_w;
    shift_d = shift_w;
    idx_d   = idx_w;
    done    = 1'b0;
    tmo     = 1'b0;

    unique case (phase_w)
      PhIdle: ;
      PhWait: begin
        if (!rx_level_i) begin
          phase_d = PhHalf;
          timer_d = '0;
        end else if (left_w == '0) begin
          phase_d = PhIdle;
          tmo     = 1'b1;
        end else if (!armed) begin
          pre_d = pre_inc;
          if (pre_inc >= ticks_per_usec_i) begin
            pre_d  = '0;
            left_d = left_w - uart8n1_pkg::TmoW'(1);
          end
        end
      end
      PhHalf: begin
        timer_d = timer_inc;
        if (timer_inc >= half) begin
          phase_d = PhData;
          timer_d = '0;
          idx_d   = '0;
        end
      end
      PhData: begin
        timer_d = timer_inc;
        if (timer_inc >= period_i) begin
          timer_d = '0;
          if (idx_w < uart8n1_pkg::RxIdxW'(uart8n1_pkg::DataBits)) begin
            shift_d[idx_w[$clog2(uart8n1_pkg::DataBits)-1:0]] =
              shift_w[idx_w[$clog2(uart8n1_pkg::DataBits)-1:0]] | rx_level_i;
          end
          idx_d = idx_inc;
          if (idx_inc >= uart8n1_pkg::RxIdxW'(uart8n1_pkg::DataBits)) begin
            phase_d = PhStop;
          end
        end
      end
      PhStop: begin
        timer_d = timer_inc;
        if (timer_inc >= period_i) begin
          timer_d = '0;
          phase_d = PhIdle;
          done    = 1'b1;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      timer_q <= '0;
      pre_q   <= '0;
      left_q  <= '0;
      shift_q <= '0;
      idx_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      pre_q   <= pre_d;
      left_q  <= left_d;
      shift_q <= shift_d;
      idx_q   <= idx_d;
    end
  end

  assign stat_o.busy    = (phase_d != PhIdle);
  assign stat_o.done    = done;
  assign stat_o.data    = done ? shift_d : '0;
  assign stat_o.timeout = tmo;

endmodule

// ===== rtl/uart_8n1_transceiver.sv =====
`timescale 1ns / 1ps
// 8N1 UART transceiver top: config registers, tx/rx cores, result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, rx_level_i ...    | one tick word in
//  out     | out_valid_o, out_stall_i, tx_level_o ...  | one status word out
//  cfg     | cfg_we_i, cfg_addr_i, cfg_wdata_i         | register write
//
// One word in, one word out; a word is taken every cycle while the result
// register is empty or being drained, and its status word shows in the next cycle.
// Reset clears both cores to idle with the line high and loads default timing.
// A stall on the output holds the result and stalls the input for that cycle.
module uart_8n1_transceiver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_addr_i,
  input  logic [uart8n1_pkg::TimerW-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                rx_level_i,
  input  logic                                send_start_i,
  input  logic [7:0]                          send_byte_i,
  input  logic                                recv_start_i,
  input  logic [31:0]                         wait_usec_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                tx_level_o,
  output logic                                tx_busy_o,
  output logic                                rx_busy_o,
  output logic                                rx_done_o,
  output logic [7:0]                          rx_byte_o,
  output logic                                rx_timeout_o
);

  logic [uart8n1_pkg::TimerW-1:0] cpb_q;
  logic [uart8n1_pkg::UsecW-1:0]  tpu_q;
  logic [uart8n1_pkg::TimerW-1:0] period;
  logic                           step;
  logic                           out_valid_q, out_valid_d;
  uart8n1_pkg::tx_stat_t          tx_stat;
  uart8n1_pkg::rx_stat_t          rx_stat;
  uart8n1_pkg::tx_stat_t          tx_res_q;
  uart8n1_pkg::rx_stat_t          rx_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpb_q <= uart8n1_pkg::CyclesPerBitRst;
      tpu_q <= uart8n1_pkg::TicksPerUsecRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        uart8n1_pkg::CfgCyclesPerBit: cpb_q <= cfg_wdata_i;
        uart8n1_pkg::CfgTicksPerUsec: tpu_q <= cfg_wdata_i[uart8n1_pkg::UsecW-1:0];
        default: ;
      endcase
    end
  end

  assign period = (cpb_q == '0) ? uart8n1_pkg::TimerW'(1) : cpb_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;

  uart8n1_tx u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .period_i     (period),
    .send_start_i (send_start_i),
    .send_byte_i  (send_byte_i),
    .stat_o       (tx_stat)
  );

  uart8n1_rx u_rx (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .period_i         (period),
    .ticks_per_usec_i (tpu_q),
    .rx_level_i       (rx_level_i),
    .recv_start_i     (recv_start_i),
    .wait_usec_i      (wait_usec_i),
    .stat_o           (rx_stat)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      tx_res_q <= tx_stat;
      rx_res_q <= rx_stat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_level_o   = tx_res_q.level;
  assign tx_busy_o    = tx_res_q.busy;
  assign rx_busy_o    = rx_res_q.busy;
  assign rx_done_o    = rx_res_q.done;
  assign rx_byte_o    = rx_res_q.data;
  assign rx_timeout_o = rx_res_q.timeout;

endmodule

// ===== test/uart_8n1_check.sv =====
`timescale 1ns / 1ps
// Checker for the 8N1 UART transceiver: line model, expected status queue, compare.
module uart_8n1_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_addr_i,
  input  logic [uart8n1_pkg::TimerW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           rx_level_i,
  input  logic                           send_start_i,
  input  logic [7:0]                     send_byte_i,
  input  logic                           recv_start_i,
  input  logic [31:0]                    wait_usec_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           tx_level_i,
  input  logic                           tx_busy_i,
  input  logic                           rx_busy_i,
  input  logic                           rx_done_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           rx_timeout_i,
  output int unsigned                    errors_o,
  output int unsigned                    pending_o,
  output logic                           quiet_o
);

  typedef enum logic [2:0] {
    RxIdle,
    RxWait,
    RxHalf,
    RxData,
    RxStop
  } rx_phase_e;

  typedef struct packed {
    logic       tx_level;
    logic       tx_busy;
    logic       rx_busy;
    logic       rx_done;
    logic [7:0] rx_byte;
    logic       rx_timeout;
  } line_status_t;

  logic [uart8n1_pkg::TimerW-1:0] bit_ticks_cfg;
  logic [uart8n1_pkg::UsecW-1:0]  usec_ticks_cfg;

  logic                           tx_on;
  logic [7:0]                     tx_data;
  logic [3:0]                     tx_slot;
  logic [uart8n1_pkg::TimerW-1:0] tx_cnt;
  logic                           tx_line;

  rx_phase_e                      rx_ph;
  logic [uart8n1_pkg::TimerW-1:0] rx_cnt;
  logic [uart8n1_pkg::UsecW-1:0]  rx_pre;
  logic [31:0]                    rx_usec;
  logic [7:0]                     rx_data;
  logic [3:0]                     rx_slot;

  line_status_t      status_q[$];
  line_status_t      want;
  line_status_t      got;
  int unsigned       err_n;
  int unsigned       words_out;

  function automatic line_status_t tick_uart(input logic lvl, input logic snd,
                                             input logic [7:0] byte_in, input logic arm,
                                             input logic [31:0] usec_in);
    line_status_t                   s;
    logic [uart8n1_pkg::TimerW-1:0] n;
    logic [uart8n1_pkg::TimerW-1:0] half;
    logic                           fresh;
    n     = (bit_ticks_cfg == '0) ? uart8n1_pkg::TimerW'(1) : bit_ticks_cfg;
    half  = n >> 1;
    fresh = 1'b0;
    s     = '0;

    if (tx_on) begin
      tx_cnt = tx_cnt + 1'b1;
      if (tx_cnt >= n) begin
        tx_cnt  = '0;
        tx_slot = tx_slot + 1'b1;
        if (tx_slot > 4'(uart8n1_pkg::DataBits + 1)) begin
          tx_on   = 1'b0;
          tx_slot = '0;
          tx_line = 1'b1;
        end else if (tx_slot <= 4'(uart8n1_pkg::DataBits)) begin
          tx_line = tx_data[3'(tx_slot - 4'd1)];
        end else begin
          tx_line = 1'b1;
        end
      end
    end else if (snd) begin
      tx_on   = 1'b1;
      tx_data = byte_in;
      tx_slot = '0;
      tx_cnt  = '0;
      tx_line = 1'b0;
    end

    if (rx_ph == RxIdle && arm) begin
      rx_ph   = RxWait;
      rx_usec = usec_in;
      rx_pre  = '0;
      rx_data = '0;
      rx_slot = '0;
      rx_cnt  = '0;
      fresh   = 1'b1;
    end

    case (rx_ph)
      RxWait: begin
        if (!lvl) begin
          rx_ph  = RxHalf;
          rx_cnt = '0;
        end else if (rx_usec == '0) begin
          rx_ph        = RxIdle;
          s.rx_timeout = 1'b1;
        end else if (!fresh) begin
          rx_pre = rx_pre + 1'b1;
          if (rx_pre >= usec_ticks_cfg) begin
            rx_pre  = '0;
            rx_usec = rx_usec - 1'b1;
          end
        end
      end
      RxHalf: begin
        rx_cnt = rx_cnt + 1'b1;
        if (rx_cnt >= half) begin
          rx_ph   = RxData;
          rx_cnt  = '0;
          rx_slot = '0;
        end
      end
      RxData: begin
        rx_cnt = rx_cnt + 1'b1;
        if (rx_cnt >= n) begin
          rx_cnt = '0;
          if (lvl && rx_slot < 4'(uart8n1_pkg::DataBits)) rx_data[rx_slot[2:0]] = 1'b1;
          rx_slot = rx_slot + 1'b1;
          if (rx_slot >= 4'(uart8n1_pkg::DataBits)) rx_ph = RxStop;
        end
      end
      RxStop: begin
        rx_cnt = rx_cnt + 1'b1;
        if (rx_cnt >= n) begin
          rx_cnt    = '0;
          rx_ph     = RxIdle;
          s.rx_done = 1'b1;
        end
      end
      default: ;
    endcase

    s.tx_level = tx_line;
    s.tx_busy  = tx_on;
    s.rx_busy  = (rx_ph != RxIdle);
    s.rx_byte  = s.rx_done ? rx_data : 8'h00;
    return s;
  endfunction

  task automatic report(input string what);
    if (err_n < 10) $display("uart check: word %0d: %s", words_out, what);
    err_n++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_cfg  = uart8n1_pkg::CyclesPerBitRst;
      usec_ticks_cfg = uart8n1_pkg::TicksPerUsecRst;
      tx_on          = 1'b0;
      tx_data        = '0;
      tx_slot        = '0;
      tx_cnt         = '0;
      tx_line        = 1'b1;
      rx_ph          = RxIdle;
      rx_cnt         = '0;
      rx_pre         = '0;
      rx_usec        = '0;
      rx_data        = '0;
      rx_slot        = '0;
      status_q.delete();
      err_n          = 0;
      words_out      = 0;
      errors_o      <= 0;
      pending_o     <= 0;
      quiet_o       <= 1'b1;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.tx_level   = tx_level_i;
        got.tx_busy    = tx_busy_i;
        got.rx_busy    = rx_busy_i;
        got.rx_done    = rx_done_i;
        got.rx_byte    = rx_byte_i;
        got.rx_timeout = rx_timeout_i;
        if (status_q.size() == 0) begin
          report("status word with nothing expected");
        end else begin
          want = status_q.pop_front();
          if (got.tx_level !== want.tx_level || got.tx_busy !== want.tx_busy ||
              got.rx_busy !== want.rx_busy || got.rx_done !== want.rx_done ||
              got.rx_byte !== want.rx_byte || got.rx_timeout !== want.rx_timeout)
            report($sformatf({"exp/got tx_level %b/%b tx_busy %b/%b rx_busy %b/%b ",
                              "rx_done %b/%b rx_byte %h/%h rx_timeout %b/%b"},
                             want.tx_level, got.tx_level, want.tx_busy, got.tx_busy,
                             want.rx_busy, got.rx_busy, want.rx_done, got.rx_done,
                             want.rx_byte, got.rx_byte, want.rx_timeout, got.rx_timeout));
        end
        words_out++;
      end

      if (cfg_we_i) begin
        case (uart8n1_pkg::cfg_reg_e'(cfg_addr_i))
          uart8n1_pkg::CfgCyclesPerBit: bit_ticks_cfg  = cfg_wdata_i;
          uart8n1_pkg::CfgTicksPerUsec: usec_ticks_cfg = cfg_wdata_i[uart8n1_pkg::UsecW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i)
        status_q.push_back(tick_uart(rx_level_i, send_start_i, send_byte_i, recv_start_i,
                                     wait_usec_i));

      errors_o  <= err_n;
      pending_o <= status_q.size();
      quiet_o   <= !tx_on && (rx_ph == RxIdle);
    end
  end

endmodule

// ===== test/uart_8n1_transceiver_test.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the 8N1 UART transceiver, with the checker beside the block.
module uart_8n1_transceiver_test;

  localparam int unsigned StallLimit = 2000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [0:0]                     cfg_addr = 1'b0;
  logic [uart8n1_pkg::TimerW-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           rx_level = 1'b1;
  logic                           send_start = 1'b0;
  logic [7:0]                     send_byte = 8'h00;
  logic                           recv_start = 1'b0;
  logic [31:0]                    wait_usec = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           tx_level;
  logic                           tx_busy;
  logic                           rx_busy;
  logic                           rx_done;
  logic [7:0]                     rx_byte;
  logic                           rx_timeout;

  int unsigned       errors;
  int unsigned       pending;
  logic              model_quiet;

  int unsigned       gap_pct = 8;
  int unsigned       stall_pct = 67;
  int unsigned       idle_cycles = 0;

  // serial frame being played onto the receive line
  int unsigned       cur_bit_ticks = 6076;
  logic [9:0]        line_bits = '1;
  logic              line_on = 1'b0;
  logic [3:0]        line_slot = '0;
  int unsigned       line_cnt = 0;

  int unsigned       phase_bits[6] = '{2, 5, 3, 8, 4, 6};
  int unsigned       phase_usec[6] = '{1, 3, 1023, 2, 7, 1};

  always #10 clk = ~clk;

  uart_8n1_transceiver u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_level_i     (rx_level),
    .send_start_i   (send_start),
    .send_byte_i    (send_byte),
    .recv_start_i   (recv_start),
    .wait_usec_i    (wait_usec),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .tx_level_o     (tx_level),
    .tx_busy_o      (tx_busy),
    .rx_busy_o      (rx_busy),
    .rx_done_o      (rx_done),
    .rx_byte_o      (rx_byte),
    .rx_timeout_o   (rx_timeout)
  );

  uart_8n1_check u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .rx_level_i     (rx_level),
    .send_start_i   (send_start),
    .send_byte_i    (send_byte),
    .recv_start_i   (recv_start),
    .wait_usec_i    (wait_usec),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .tx_level_i     (tx_level),
    .tx_busy_i      (tx_busy),
    .rx_busy_i      (rx_busy),
    .rx_done_i      (rx_done),
    .rx_byte_i      (rx_byte),
    .rx_timeout_i   (rx_timeout),
    .errors_o       (errors),
    .pending_o      (pending),
    .quiet_o        (model_quiet)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("uart_8n1_transceiver_test: done, errors");
    $finish;
  end

  task automatic line_start(input logic [7:0] b);
    line_bits = {1'b1, b, 1'b0};
    line_on   = 1'b1;
    line_slot = '0;
    line_cnt  = 0;
  endtask

  function automatic logic line_level();
    logic lv;
    if (!line_on) return 1'b1;
    lv = line_bits[line_slot];
    line_cnt++;
    if (line_cnt >= cur_bit_ticks) begin
      line_cnt = 0;
      line_slot++;
      if (line_slot >= 4'd10) line_on = 1'b0;
    end
    return lv;
  endfunction

  task automatic put_word(input logic lvl, input logic snd, input logic [7:0] b,
                          input logic arm, input logic [31:0] usec);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    rx_level     <= lvl;
    send_start   <= snd;
    send_byte    <= b;
    recv_start   <= arm;
    wait_usec    <= usec;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_word();
    logic        lvl;
    logic [31:0] usec;
    int unsigned pick;
    if (line_on) begin
      lvl = line_level();
      if ($urandom_range(99) < 2) lvl = ~lvl;
    end else begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        line_start(8'($urandom_range(255)));
        lvl = line_level();
      end else begin
        lvl = (pick < 97);
      end
    end
    case ($urandom_range(7))
      0:       usec = '0;
      1, 2, 3: usec = $urandom_range(30, 1);
      4, 5:    usec = $urandom;
      default: usec = $urandom_range(300, 31);
    endcase
    put_word(lvl, $urandom_range(99) < 6, 8'($urandom_range(255)),
             $urandom_range(99) < 8, usec);
  endtask

  // hold the receive line low until both halves go quiet, then let results drain
  task automatic settle();
    line_on = 1'b0;
    do put_word(1'b0, 1'b0, 8'h00, 1'b0, '0); while (!model_quiet);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input uart8n1_pkg::cfg_reg_e r,
                           input logic [uart8n1_pkg::TimerW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (r == uart8n1_pkg::CfgCyclesPerBit) cur_bit_ticks = 32'(v);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing: zero timeout, then one microsecond at the default prescale
    put_word(1'b1, 1'b0, 8'h00, 1'b1, '0);
    put_word(1'b1, 1'b0, 8'h00, 1'b1, 32'd1);
    repeat (705) put_word(1'b1, 1'b0, 8'h00, 1'b0, '0);
    settle();

    write_reg(uart8n1_pkg::CfgCyclesPerBit, uart8n1_pkg::TimerW'(2));
    write_reg(uart8n1_pkg::CfgTicksPerUsec, uart8n1_pkg::TimerW'(1));
    put_word(1'b1, 1'b0, 8'h00, 1'b0, '0);
    put_word(1'b1, 1'b0, 8'h00, 1'b1, '0);
    put_word(1'b1, 1'b0, 8'h00, 1'b1, 32'd3);
    put_word(1'b1, 1'b0, 8'h00, 1'b1, 32'hFFFF_FFFF);
    repeat (3) put_word(1'b1, 1'b0, 8'h00, 1'b0, '0);
    // frames both ways; send held high across the end tick of the first frame
    line_start(8'hFF);
    for (int k = 0; k < 23; k++)
      put_word(line_level(), 1'b1, (k == 0) ? 8'h00 : (k == 21) ? 8'hFF : 8'(k * 37),
               (k == 0 || k == 5), '0);

    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(uart8n1_pkg::CfgCyclesPerBit, uart8n1_pkg::TimerW'(phase_bits[p]));
      write_reg(uart8n1_pkg::CfgTicksPerUsec, uart8n1_pkg::TimerW'(phase_usec[p]));
      if (p < 2) begin
        gap_pct   = 8;
        stall_pct = 67;
      end else if (p < 4) begin
        gap_pct   = 67;
        stall_pct = 8;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      for (int w = 0; w < 180; w++) begin
        if (w == 90) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending != 0);
        end
        random_word();
      end
    end

    settle();
    write_reg(uart8n1_pkg::CfgCyclesPerBit, '1);
    write_reg(uart8n1_pkg::CfgTicksPerUsec, uart8n1_pkg::TimerW'(1023));
    put_word(1'b1, 1'b1, 8'hA5, 1'b1, 32'hFFFF_FFFF);
    repeat (10) put_word(1'b1, 1'b1, 8'($urandom_range(255)), 1'b1, $urandom);
    put_word(1'b0, 1'b0, 8'h00, 1'b0, '0);
    repeat (10) put_word(1'($urandom_range(1)), 1'b0, 8'h00, 1'b0, '0);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("uart_8n1_transceiver_test: done, clean");
    end else begin
      $display("uart_8n1_transceiver_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/uart8n1_pkg.sv
rtl/uart8n1_tx.sv
rtl/uart8n1_rx.sv
rtl/uart_8n1_transceiver.sv
test/uart_8n1_check.sv
test/uart_8n1_transceiver_test.sv
